// ===== hdl/dcr_pkg.sv =====
package dcr_pkg;

    localparam int DCR_COORD_WIDTH = 32;
    localparam int DCR_SQRT_SIDE   = 4 * DCR_COORD_WIDTH + 5;
    localparam int DCR_DIV_SIDE    = DCR_COORD_WIDTH + 7;
    localparam int DCR_LANES       = 3;

endpackage

// ===== hdl/distance_constraint_relax_top.sv =====
// channel | valid       | stall        | payload
// input   | i_in_valid  | o_in_stall   | i_first_*, i_second_*, flags, i_rest_length
// output  | o_out_valid | i_out_stall  | o_first_d*, o_second_d*, o_current_length, o_degenerate
//
// One item per cycle while o_in_stall is low; the pipeline holds the COORD_WIDTH+1 root
// cells and the 2*COORD_WIDTH+2 divider cells.
// Synchronous active-low reset clears valid bits only.
// A stalled result waits in the output register; one more item lands in a skid
// register, then the whole chain holds and o_in_stall rises until the skid drains.
module distance_constraint_relax_top #(
    parameter int COORD_WIDTH = dcr_pkg::DCR_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_z,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_z,
    input  logic                          i_first_movable,
    input  logic                          i_second_movable,
    input  logic [COORD_WIDTH-2:0]        i_rest_length,
    input  logic                          i_link_enabled,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_first_dx,
    output logic signed [COORD_WIDTH-1:0] o_first_dy,
    output logic signed [COORD_WIDTH-1:0] o_first_dz,
    output logic signed [COORD_WIDTH-1:0] o_second_dx,
    output logic signed [COORD_WIDTH-1:0] o_second_dy,
    output logic signed [COORD_WIDTH-1:0] o_second_dz,
    output logic [COORD_WIDTH+1:0]        o_current_length,
    output logic                          o_degenerate
);
    import dcr_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int SQS   = 4 * W + 5;
    localparam int DVS   = W + 7;
    localparam int NSQ   = W + 1;
    localparam int NDV   = 2 * W + 2;
    localparam int PAYW  = 6 * W + W + 3;
    localparam logic [2*W+1:0] LIM_NEG = (2*W+2)'(1) << (W - 1);
    localparam logic [2*W+1:0] LIM_POS = LIM_NEG - (2*W+2)'(1);

    logic en;

    // input stage
    logic                r_a_valid;
    logic signed [W-1:0] r_a_p1 [3];
    logic signed [W-1:0] r_a_p2 [3];
    logic                r_a_m1, r_a_m2, r_a_en;
    logic [W-2:0]        r_a_rest;

    // difference
    logic signed [W:0]   b_diff [3];
    logic [W:0]          b_mag  [3];
    logic                r_b_valid;
    logic [W-1:0]        r_b_dmag [3];
    logic [2:0]          r_b_dneg;
    logic                r_b_m1, r_b_m2, r_b_en;
    logic [W-2:0]        r_b_rest;

    // squares
    logic                r_c_valid;
    logic [2*W-1:0]      r_c_sq [3];
    logic [W-1:0]        r_c_dmag [3];
    logic [2:0]          r_c_dneg;
    logic                r_c_m1, r_c_m2, r_c_en;
    logic [W-2:0]        r_c_rest;

    // sum
    logic                r_d_valid;
    logic [2*W+1:0]      r_d_sum;
    logic [SQS-1:0]      r_d_side;

    // root chain
    logic                sq_valid [NSQ+1];
    logic [2*W+1:0]      sq_rad   [NSQ+1];
    logic [W+1:0]        sq_rem   [NSQ+1];
    logic [W:0]          sq_root  [NSQ+1];
    logic [SQS-1:0]      sq_side  [NSQ+1];

    // correction setup
    logic [W:0]          e_len;
    logic [W-1:0]        e_dmag [3];
    logic [2:0]          e_dneg;
    logic                e_m1, e_m2, e_en;
    logic [W:0]          e_rest;
    logic                e_diffneg;
    logic                r_e_valid;
    logic [W-1:0]        r_e_dmag [3];
    logic [W:0]          r_e_diffmag;
    logic [W+1:0]        r_e_den;
    logic [DVS-1:0]      r_e_side;

    // products
    logic                r_f_valid;
    logic [2*W:0]        r_f_prod [3];
    logic [W+1:0]        r_f_den;
    logic [DVS-1:0]      r_f_side;

    // numerators
    logic                r_g_valid;
    logic [2*W+1:0]      r_g_num [3];
    logic [W+1:0]        r_g_den;
    logic [DVS-1:0]      r_g_side;

    // divider chain
    logic                dv_valid [NDV+1];
    logic [W+1:0]        dv_den   [NDV+1];
    logic [W+1:0]        dv_rem   [NDV+1][3];
    logic [2*W+1:0]      dv_nq    [NDV+1][3];
    logic [DVS-1:0]      dv_side  [NDV+1];

    // final
    logic [2:0]          z_neg;
    logic                z_zero, z_m1, z_m2;
    logic [W:0]          z_len;
    logic [W-1:0]        z_first  [3];
    logic [W-1:0]        z_second [3];
    logic [PAYW-1:0]     z_pay;

    logic                r_ov, r_sv;
    logic [PAYW-1:0]     r_o_pay, r_s_pay;

    function automatic logic [W-1:0] sat(input logic [2*W+1:0] q, input logic neg);
        logic [W-1:0] m;
        if (neg) begin
            m = (q > LIM_NEG) ? LIM_NEG[W-1:0] : q[W-1:0];
            sat = (~m) + W'(1);
        end else begin
            sat = (q > LIM_POS) ? LIM_POS[W-1:0] : q[W-1:0];
        end
    endfunction

    assign en         = !r_sv;
    assign o_in_stall = r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= sq_valid[NSQ];
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b_diff[i] = {r_a_p2[i][W-1], r_a_p2[i]} - {r_a_p1[i][W-1], r_a_p1[i]};
            b_mag[i]  = b_diff[i][W] ? (~b_diff[i] + (W+1)'(1)) : b_diff[i];
        end
    end

    assign e_len  = sq_root[NSQ];
    assign {e_dmag[2], e_dmag[1], e_dmag[0], e_dneg, e_m1, e_m2, e_en} =
        sq_side[NSQ][SQS-1:W-1];
    assign e_rest    = {2'b00, sq_side[NSQ][W-2:0]};
    assign e_diffneg = e_len < e_rest;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_p1[0] <= i_first_x;
            r_a_p1[1] <= i_first_y;
            r_a_p1[2] <= i_first_z;
            r_a_p2[0] <= i_second_x;
            r_a_p2[1] <= i_second_y;
            r_a_p2[2] <= i_second_z;
            r_a_m1    <= i_first_movable;
            r_a_m2    <= i_second_movable;
            r_a_en    <= i_link_enabled;
            r_a_rest  <= i_rest_length;

            for (int i = 0; i < 3; i++) begin
                r_b_dmag[i] <= b_mag[i][W-1:0];
                r_b_dneg[i] <= b_diff[i][W];
            end
            r_b_m1   <= r_a_m1;
            r_b_m2   <= r_a_m2;
            r_b_en   <= r_a_en;
            r_b_rest <= r_a_rest;

            for (int i = 0; i < 3; i++) begin
                r_c_sq[i]   <= r_b_dmag[i] * r_b_dmag[i];
                r_c_dmag[i] <= r_b_dmag[i];
            end
            r_c_dneg <= r_b_dneg;
            r_c_m1   <= r_b_m1;
            r_c_m2   <= r_b_m2;
            r_c_en   <= r_b_en;
            r_c_rest <= r_b_rest;

            r_d_sum  <= {2'b00, r_c_sq[0]} + {2'b00, r_c_sq[1]} + {2'b00, r_c_sq[2]};
            r_d_side <= {r_c_dmag[2], r_c_dmag[1], r_c_dmag[0], r_c_dneg,
                         r_c_m1, r_c_m2, r_c_en, r_c_rest};

            r_e_dmag    <= e_dmag;
            r_e_diffmag <= e_diffneg ? (e_rest - e_len) : (e_len - e_rest);
            r_e_den     <= (e_m1 && e_m2) ? {e_len, 1'b0} : {1'b0, e_len};
            r_e_side    <= {e_dneg ^ {3{e_diffneg}},
                            (!e_en || (e_len == '0) || (!e_m1 && !e_m2)),
                            e_m1, e_m2, e_len};

            for (int i = 0; i < 3; i++) begin
                r_f_prod[i] <= r_e_dmag[i] * r_e_diffmag;
            end
            r_f_den  <= r_e_den;
            r_f_side <= r_e_side;

            for (int i = 0; i < 3; i++) begin
                r_g_num[i] <= {1'b0, r_f_prod[i]} + (2*W+2)'(r_f_den >> 1);
            end
            r_g_den  <= r_f_den;
            r_g_side <= r_f_side;
        end
    end

    assign sq_valid[0] = r_d_valid;
    assign sq_rad[0]   = r_d_sum;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = r_d_side;

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        dcr_sqrt_cell #(.W(W), .SIDE(SQS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_valid[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    assign dv_valid[0] = r_g_valid;
    assign dv_den[0]   = r_g_den;
    assign dv_side[0]  = r_g_side;
    for (genvar i = 0; i < 3; i++) begin : g_dv_in
        assign dv_rem[0][i] = '0;
        assign dv_nq[0][i]  = r_g_num[i];
    end

    for (genvar k = 0; k < NDV; k++) begin : g_div
        dcr_div_cell #(.W(W), .LANES(3), .SIDE(DVS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[k]),
            .i_den   (dv_den[k]),
            .i_rem   (dv_rem[k]),
            .i_nq    (dv_nq[k]),
            .i_side  (dv_side[k]),
            .o_valid (dv_valid[k+1]),
            .o_den   (dv_den[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_nq    (dv_nq[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    assign {z_neg, z_zero, z_m1, z_m2, z_len} = dv_side[NDV];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            z_first[i]  = (!z_zero && z_m1) ? sat(dv_nq[NDV][i], z_neg[i])  : '0;
            z_second[i] = (!z_zero && z_m2) ? sat(dv_nq[NDV][i], !z_neg[i]) : '0;
        end
        z_pay = {z_first[0], z_first[1], z_first[2],
                 z_second[0], z_second[1], z_second[2],
                 1'b0, z_len, (z_len == '0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || !i_out_stall) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= dv_valid[NDV];
            end
        end else if (en && dv_valid[NDV]) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_out_stall) begin
            r_o_pay <= r_sv ? r_s_pay : z_pay;
        end
        if (en) begin
            r_s_pay <= z_pay;
        end
    end

    assign o_out_valid = r_ov;
    assign {o_first_dx, o_first_dy, o_first_dz,
            o_second_dx, o_second_dy, o_second_dz,
            o_current_length, o_degenerate} = r_o_pay;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds an item with no item in the output register");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_out_stall) |=> (r_ov && !r_sv))
        else $error("skid item not moved to output");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |->
            (o_current_length == '0 && o_first_dx == '0 && o_first_dy == '0 &&
             o_first_dz == '0 && o_second_dx == '0 && o_second_dy == '0 &&
             o_second_dz == '0))
        else $error("degenerate item with nonzero move or length");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && $past(i_out_stall)))
        else $error("input stalled without a blocked result");
`endif

endmodule

// ===== hdl/dcr_sqrt_cell.sv =====
module dcr_sqrt_cell #(
    parameter int W    = dcr_pkg::DCR_COORD_WIDTH,
    parameter int SIDE = dcr_pkg::DCR_SQRT_SIDE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*W+1:0]    i_rad,
    input  logic [W+1:0]      i_rem,
    input  logic [W:0]        i_root,
    input  logic [SIDE-1:0]   i_side,
    output logic              o_valid,
    output logic [2*W+1:0]    o_rad,
    output logic [W+1:0]      o_rem,
    output logic [W:0]        o_root,
    output logic [SIDE-1:0]   o_side
);
    import dcr_pkg::*;

    logic [W+3:0] t;
    logic [W+3:0] trial;
    logic [W+3:0] diff;
    logic         ge;
    logic [W+1:0] n_rem;
    logic [W:0]   n_root;

    logic              r_valid;
    logic [2*W+1:0]    r_rad;
    logic [W+1:0]      r_rem;
    logic [W:0]        r_root;
    logic [SIDE-1:0]   r_side;

    assign t      = {i_rem, i_rad[2*W+1:2*W]};
    assign trial  = {1'b0, i_root, 2'b01};
    assign ge     = t >= trial;
    assign diff   = t - trial;
    assign n_rem  = ge ? diff[W+1:0] : t[W+1:0];
    assign n_root = {i_root[W-1:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[2*W-1:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

// ===== hdl/dcr_div_cell.sv =====
module dcr_div_cell #(
    parameter int W     = dcr_pkg::DCR_COORD_WIDTH,
    parameter int LANES = dcr_pkg::DCR_LANES,
    parameter int SIDE  = dcr_pkg::DCR_DIV_SIDE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W+1:0]      i_den,
    input  logic [W+1:0]      i_rem [LANES],
    input  logic [2*W+1:0]    i_nq  [LANES],
    input  logic [SIDE-1:0]   i_side,
    output logic              o_valid,
    output logic [W+1:0]      o_den,
    output logic [W+1:0]      o_rem [LANES],
    output logic [2*W+1:0]    o_nq  [LANES],
    output logic [SIDE-1:0]   o_side
);
    import dcr_pkg::*;

    logic [W+2:0]   t     [LANES];
    logic [W+2:0]   diff  [LANES];
    logic           ge    [LANES];

    logic              r_valid;
    logic [W+1:0]      r_den;
    logic [W+1:0]      r_rem [LANES];
    logic [2*W+1:0]    r_nq  [LANES];
    logic [SIDE-1:0]   r_side;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            t[i]    = {i_rem[i], i_nq[i][2*W+1]};
            ge[i]   = t[i] >= {1'b0, i_den};
            diff[i] = t[i] - {1'b0, i_den};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_side <= i_side;
            for (int i = 0; i < LANES; i++) begin
                r_rem[i] <= ge[i] ? diff[i][W+1:0] : t[i][W+1:0];
                r_nq[i]  <= {i_nq[i][2*W:0], ge[i]};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_side  = r_side;

endmodule

// ===== sim/distance_constraint_relax_top_tb.sv =====
module distance_constraint_relax_top_tb;

    localparam int CW = dcr_pkg::DCR_COORD_WIDTH;
    localparam int LATENCY = 3 * CW + 11;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [CW-1:0] fx, fy, fz, sx, sy, sz;
        logic                 fm, sm;
        logic [CW-2:0]        rest;
        logic                 en;
    } link_t;

    typedef struct {
        logic signed [CW-1:0] fdx, fdy, fdz, sdx, sdy, sdz;
        logic [CW+1:0]        len;
        logic                 degen;
    } moves_t;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic signed [CW-1:0] i_first_x, i_first_y, i_first_z;
    logic signed [CW-1:0] i_second_x, i_second_y, i_second_z;
    logic i_first_movable, i_second_movable;
    logic [CW-2:0] i_rest_length;
    logic i_link_enabled;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [CW-1:0] o_first_dx, o_first_dy, o_first_dz;
    logic signed [CW-1:0] o_second_dx, o_second_dy, o_second_dz;
    logic [CW+1:0] o_current_length;
    logic o_degenerate;

    distance_constraint_relax_top dut (.*);

    moves_t pending_moves[$];
    bit     failed;
    int     idle_cycles;
    int     send_gap_pct;
    int     stall_pct;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [CW-1:0] saturate(logic [127:0] mag, logic neg);
        logic [CW-1:0] lim;
        logic [CW-1:0] m;
        lim = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        m = (mag > 128'(lim)) ? lim : mag[CW-1:0];
        return neg ? -m : m;
    endfunction

    function automatic moves_t relax_link(link_t l);
        moves_t r;
        logic [CW-1:0] dmag[3];
        logic dneg[3];
        logic signed [CW:0] a, b;
        logic [127:0] sum, q, t;
        logic [63:0] len, root, diffmag, den;
        logic diffneg, neg;
        logic [CW-1:0] sat;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0: begin a = l.fx; b = l.sx; end
                1: begin a = l.fy; b = l.sy; end
                default: begin a = l.fz; b = l.sz; end
            endcase
            dneg[i] = b < a;
            dmag[i] = dneg[i] ? CW'(a - b) : CW'(b - a);
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += 128'(dmag[i]) * 128'(dmag[i]);
        root = 0;
        for (int k = 63; k >= 0; k--) begin
            len = root | (64'd1 << k);
            t = 128'(len) * 128'(len);
            if (t <= sum) root = len;
        end
        len = root;
        r = '{default: '0};
        r.len = len[CW+1:0];
        r.degen = (len == 0);
        if (!l.en || len == 0 || (!l.fm && !l.sm)) return r;
        diffneg = len < l.rest;
        diffmag = diffneg ? (64'(l.rest) - len) : (len - 64'(l.rest));
        den = (l.fm && l.sm) ? (len << 1) : len;
        for (int i = 0; i < 3; i++) begin
            q = (128'(dmag[i]) * 128'(diffmag) + 128'(den >> 1)) / 128'(den);
            neg = dneg[i] != diffneg;
            if (l.fm) begin
                sat = saturate(q, neg);
                case (i)
                    0: r.fdx = sat;
                    1: r.fdy = sat;
                    default: r.fdz = sat;
                endcase
            end
            if (l.sm) begin
                sat = saturate(q, !neg);
                case (i)
                    0: r.sdx = sat;
                    1: r.sdy = sat;
                    default: r.sdz = sat;
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_link(link_t l);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_first_x        <= l.fx;
        i_first_y        <= l.fy;
        i_first_z        <= l.fz;
        i_second_x       <= l.sx;
        i_second_y       <= l.sy;
        i_second_z       <= l.sz;
        i_first_movable  <= l.fm;
        i_second_movable <= l.sm;
        i_rest_length    <= l.rest;
        i_link_enabled   <= l.en;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_moves.push_back(relax_link(l));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(int spread);
        case (spread)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(65535 * 64)) - 32 * 65535);
            default: return CW'($signed($urandom_range(4095)) - 2048);
        endcase
    endfunction

    function automatic link_t rand_link();
        link_t l;
        int spread;
        spread = $urandom_range(2);
        l.fx = rand_coord(spread);
        l.fy = rand_coord(spread);
        l.fz = rand_coord(spread);
        if ($urandom_range(9) == 0) begin
            l.sx = l.fx; l.sy = l.fy; l.sz = l.fz;
        end else begin
            l.sx = rand_coord(spread);
            l.sy = rand_coord(spread);
            l.sz = rand_coord(spread);
        end
        l.fm = 1'($urandom_range(1));
        l.sm = 1'($urandom_range(1));
        case ($urandom_range(2))
            0: l.rest = (CW-1)'($urandom);
            1: l.rest = (CW-1)'($urandom_range(65535 * 64));
            default: l.rest = (CW-1)'($urandom_range(4095));
        endcase
        l.en = ($urandom_range(7) != 0);
        return l;
    endfunction

    function automatic link_t make_link(logic [CW-1:0] fx, fy, fz, sx, sy, sz,
                                        logic fm, sm, logic [CW-2:0] rest, logic en);
        link_t l;
        l.fx = fx; l.fy = fy; l.fz = fz; l.sx = sx; l.sy = sy; l.sz = sz;
        l.fm = fm; l.sm = sm; l.rest = rest; l.en = en;
        return l;
    endfunction

    task automatic test_directed;
        localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
        localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
        localparam logic [CW-2:0] RMAX = '1;
        send_gap_pct = 0;
        stall_pct = 0;
        send_link(make_link(0, 0, 0, 'h30000, 'h40000, 0, 1, 1, 'h10000, 1));
        send_link(make_link(0, 0, 0, 'h30000, 'h40000, 0, 1, 0, 'h10000, 1));
        send_link(make_link(0, 0, 0, 'h30000, 'h40000, 0, 0, 1, 'h10000, 1));
        send_link(make_link(0, 0, 0, 'h30000, 'h40000, 0, 0, 0, 'h10000, 1));
        send_link(make_link(0, 0, 0, 'h30000, 'h40000, 0, 1, 1, 'h10000, 0));
        send_link(make_link(5, 6, 7, 5, 6, 7, 1, 1, 'h10000, 1));
        send_link(make_link(MINV, MINV, MINV, MAXV, MAXV, MAXV, 1, 1, 0, 1));
        send_link(make_link(MAXV, MAXV, MAXV, MINV, MINV, MINV, 1, 0, RMAX, 1));
        send_link(make_link(MINV, 0, 0, MAXV, 0, 0, 0, 1, RMAX, 1));
        send_link(make_link(0, 0, 0, 1, 0, 0, 1, 0, RMAX, 1));
        send_link(make_link(0, 0, 0, 0, 0, 1, 0, 1, RMAX, 1));
        send_link(make_link(0, 0, 0, 3, 0, 0, 1, 1, 2, 1));
        send_link(make_link(0, 0, 0, 3, 0, 0, 1, 1, 0, 1));
        send_link(make_link('1, '1, '1, 0, 0, 0, 1, 1, 3, 1));
        send_link(make_link(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1, 1, RMAX, 1));
        send_link(make_link(MINV, MAXV, 0, MAXV, MINV, 0, 1, 1, 1, 1));
        drain();
    endtask

    task automatic test_random(int count, int gap, int stall);
        send_gap_pct = gap;
        stall_pct = stall;
        repeat (count) send_link(rand_link());
    endtask

    task automatic test_pause_until_empty;
        test_random(20, 0, 51);
        drain();
        test_random(20, 0, 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        moves_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_moves.size() == 0) begin
                $display("%0t: result with nothing expected", $realtime);
                failed = 1'b1;
            end else begin
                e = pending_moves.pop_front();
                if ({o_first_dx, o_first_dy, o_first_dz, o_second_dx, o_second_dy,
                     o_second_dz, o_current_length, o_degenerate} !==
                    {e.fdx, e.fdy, e.fdz, e.sdx, e.sdy, e.sdz, e.len, e.degen}) begin
                    $display("%0t: expected d1=%0d,%0d,%0d d2=%0d,%0d,%0d L=%0d deg=%0b",
                             $realtime, e.fdx, e.fdy, e.fdz, e.sdx, e.sdy, e.sdz,
                             e.len, e.degen);
                    $display("%0t:   actual d1=%0d,%0d,%0d d2=%0d,%0d,%0d L=%0d deg=%0b",
                             $realtime, o_first_dx, o_first_dy, o_first_dz, o_second_dx,
                             o_second_dy, o_second_dz, o_current_length, o_degenerate);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL distance_constraint_relax_top");
                $finish;
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        failed = 1'b0;
        idle_cycles = 0;
        send_gap_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        {i_first_x, i_first_y, i_first_z, i_second_x, i_second_y, i_second_z} = '0;
        {i_first_movable, i_second_movable, i_link_enabled} = '0;
        i_rest_length = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200, 0, 0);
        test_random(200, 51, 0);
        test_random(200, 0, 51);
        test_random(200, 6, 6);
        test_pause_until_empty();
        test_random(60, 0, 0);
        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (!failed) begin
            $display("PASS distance_constraint_relax_top");
        end else begin
            $display("FAIL distance_constraint_relax_top");
        end
        $finish;
    end

endmodule
